// ===== rtl/core/tts_pkg.sv =====
package tts_pkg;

    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 32;

    localparam logic [31:0] FULL_TURN_Q16    = 32'd23592960;
    localparam logic [31:0] HALF_TURN_Q16    = 32'd11796480;
    localparam logic [31:0] QUARTER_TURN_Q16 = 32'd5898240;
    localparam logic [31:0] EXTREME_START    = 32'd6553600;
    localparam logic [31:0] ONE_Q30          = 32'd1073741824;
    localparam logic [31:0] CORDIC_GAIN_Q30  = 32'h26DD3B6A;
    localparam logic [26:0] DEG_TO_RAD_Q32   = 27'd74961321;

    // configuration register indexes
    localparam logic [7:0] REG_START  = 8'd0;
    localparam logic [7:0] REG_END    = 8'd1;
    localparam logic [7:0] REG_COUNT  = 8'd2;
    localparam logic [7:0] REG_COLUMN = 8'd3;

    // extrema column codes
    localparam logic [2:0] COL_ANGLE = 3'd0;
    localparam logic [2:0] COL_SIN   = 3'd1;
    localparam logic [2:0] COL_COS   = 3'd2;
    localparam logic [2:0] COL_TAN   = 3'd3;
    localparam logic [2:0] COL_COT   = 3'd4;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    typedef enum logic [1:0] {
        DIV_STEP = 2'd0,
        DIV_TAN  = 2'd1,
        DIV_COT  = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     div_start;
        div_sel_t div_sel;
        logic     step_save;
        logic     mul;
        logic     add;
        logic     mod_start;
        logic     fold;
        logic     rad;
        logic     cordic_init;
        logic     cordic_step;
        logic     clamp;
        logic     tan_save;
        logic     cot_save;
        logic     out_load;
    } tts_cmd_t;

    typedef struct packed {
        logic step_stale;
        logic div_done;
        logic mod_done;
        logic cordic_last;
        logic c_zero;
        logic s_zero;
        logic m_free;
    } tts_status_t;

endpackage

// ===== rtl/core/tts_div.sv =====
module tts_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [47:0] quo
);
    import tts_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [5:0]           cnt_reg;
    logic [DIV_NUM_W-1:0] work_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    assign trial = {rem_reg, work_reg[DIV_NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit a cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= num;
            den_reg  <= den;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= DIV_DEN_W'(trial - {1'b0, den_reg});
            end else begin
                rem_reg <= trial[DIV_DEN_W-1:0];
            end
            work_reg <= {work_reg[DIV_NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = work_reg;

endmodule

// ===== rtl/core/tts_ctrl.sv =====
module tts_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tts_pkg::tts_status_t status,
    output tts_pkg::tts_cmd_t    cmd
);
    import tts_pkg::*;

    typedef enum logic [15:0] {
        ST_IDLE      = 16'h0001,
        ST_STEP_GO   = 16'h0002,
        ST_STEP_WAIT = 16'h0004,
        ST_MUL       = 16'h0008,
        ST_ADD       = 16'h0010,
        ST_MOD_GO    = 16'h0020,
        ST_MOD_WAIT  = 16'h0040,
        ST_RAD       = 16'h0080,
        ST_CINIT     = 16'h0100,
        ST_CORDIC    = 16'h0200,
        ST_CLAMP     = 16'h0400,
        ST_TAN_GO    = 16'h0800,
        ST_TAN_WAIT  = 16'h1000,
        ST_COT_GO    = 16'h2000,
        ST_COT_WAIT  = 16'h4000,
        ST_TRACK     = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_STEP;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = status.step_stale ? ST_STEP_GO : ST_MUL;
                end
            end
            ST_STEP_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_STEP;
                state_next    = ST_STEP_WAIT;
            end
            ST_STEP_WAIT: begin
                if (status.div_done) begin
                    cmd.step_save = 1'b1;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.add    = 1'b1;
                state_next = ST_MOD_GO;
            end
            ST_MOD_GO: begin
                cmd.mod_start = 1'b1;
                state_next    = ST_MOD_WAIT;
            end
            ST_MOD_WAIT: begin
                if (status.mod_done) begin
                    cmd.fold   = 1'b1;
                    state_next = ST_RAD;
                end
            end
            ST_RAD: begin
                cmd.rad    = 1'b1;
                state_next = ST_CINIT;
            end
            ST_CINIT: begin
                cmd.cordic_init = 1'b1;
                state_next      = ST_CORDIC;
            end
            ST_CORDIC: begin
                cmd.cordic_step = 1'b1;
                if (status.cordic_last) begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = ST_TAN_GO;
            end
            ST_TAN_GO: begin
                if (status.c_zero) begin
                    state_next = ST_COT_GO;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_TAN;
                    state_next    = ST_TAN_WAIT;
                end
            end
            ST_TAN_WAIT: begin
                if (status.div_done) begin
                    cmd.tan_save = 1'b1;
                    state_next   = ST_COT_GO;
                end
            end
            ST_COT_GO: begin
                if (status.s_zero) begin
                    state_next = ST_TRACK;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_COT;
                    state_next    = ST_COT_WAIT;
                end
            end
            ST_COT_WAIT: begin
                if (status.div_done) begin
                    cmd.cot_save = 1'b1;
                    state_next   = ST_TRACK;
                end
            end
            ST_TRACK: begin
                if (status.m_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/tts_dp.sv =====
module tts_dp #(
    parameter int POINTS_MAX   = 1024,
    parameter int CORDIC_STEPS = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tts_pkg::tts_cmd_t    cmd,
    output tts_pkg::tts_status_t status,
    input  logic [9:0]           s_point_index,
    input  logic                 cfg_valid,
    input  logic [7:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_angle_deg,
    output logic signed [31:0]   m_sine,
    output logic signed [31:0]   m_cosine,
    output logic signed [31:0]   m_tangent,
    output logic signed [31:0]   m_cotangent,
    output logic                 m_tangent_defined,
    output logic                 m_cotangent_defined,
    output logic signed [31:0]   m_column_max,
    output logic signed [31:0]   m_column_min
);
    import tts_pkg::*;

    localparam int IW = $clog2(CORDIC_STEPS);
    localparam int CW = 34;

    function automatic logic signed [31:0] sat_quo(input logic [47:0] q, input logic neg);
        logic signed [31:0] r;
        if (neg) begin
            if (q > 48'h0000_8000_0000) begin
                r = 32'sh8000_0000;
            end else begin
                r = 32'(~q + 48'd1);
            end
        end else begin
            if (q > 48'h0000_7FFF_FFFF) begin
                r = 32'sh7FFF_FFFF;
            end else begin
                r = q[31:0];
            end
        end
        return r;
    endfunction

    // configuration
    logic signed [31:0] start_reg, end_reg;
    logic [10:0]        count_reg;
    logic [2:0]         col_reg;
    logic               stale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            end_reg   <= FULL_TURN_Q16;
            count_reg <= 11'd1;
            col_reg   <= COL_SIN;
            stale_reg <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_START: begin
                    start_reg <= cfg_data;
                    stale_reg <= 1'b1;
                end
                REG_END: begin
                    end_reg   <= cfg_data;
                    stale_reg <= 1'b1;
                end
                REG_COUNT: begin
                    count_reg <= cfg_data[10:0];
                    stale_reg <= 1'b1;
                end
                REG_COLUMN: begin
                    col_reg   <= cfg_data[2:0];
                    stale_reg <= 1'b1;
                end
                default: begin
                end
            endcase
        end else if (cmd.step_save) begin
            stale_reg <= 1'b0;
        end
    end

    // divider operand selection
    logic [31:0]        n_eff, step_den;
    logic signed [32:0] diff;
    logic [32:0]        diff_mag;
    logic signed [31:0] angle_reg, s_reg, c_reg;
    logic [31:0]        angle_mag;
    logic [30:0]        s_mag, c_mag;
    logic [47:0]        div_num;
    logic [31:0]        div_den;
    logic               div_neg, neg_reg;
    logic               div_done;
    logic [47:0]        div_quo;

    always_comb begin
        n_eff    = (32'(count_reg) > 32'(POINTS_MAX)) ? 32'(POINTS_MAX) : 32'(count_reg);
        step_den = (n_eff <= 32'd1) ? 32'd1 : n_eff - 32'd1;
        diff     = {end_reg[31], end_reg} - {start_reg[31], start_reg};
        diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
        angle_mag = angle_reg[31] ? (~angle_reg + 32'd1) : angle_reg;
        s_mag    = s_reg[31] ? 31'(-s_reg) : s_reg[30:0];
        c_mag    = c_reg[31] ? 31'(-c_reg) : c_reg[30:0];
        case (cmd.div_sel)
            DIV_STEP: begin
                div_num = 48'(diff_mag);
                div_den = step_den;
                div_neg = diff[32];
            end
            DIV_TAN: begin
                div_num = 48'({s_mag, 16'h0000});
                div_den = 32'(c_mag);
                div_neg = s_reg[31] ^ c_reg[31];
            end
            DIV_COT: begin
                div_num = 48'({c_mag, 16'h0000});
                div_den = 32'(s_mag);
                div_neg = s_reg[31] ^ c_reg[31];
            end
            default: begin
                div_num = '0;
                div_den = 32'd1;
                div_neg = 1'b0;
            end
        endcase
    end

    tts_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // angle magnitude modulo a full turn: compare and subtract the turn shifted by 6 down to 0
    logic [31:0] red_reg, red_sub;
    logic [2:0]  red_k_reg;
    logic        red_busy_reg, red_done_reg;

    assign red_sub = FULL_TURN_Q16 << red_k_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_busy_reg <= 1'b0;
            red_done_reg <= 1'b0;
        end else begin
            red_done_reg <= 1'b0;
            if (cmd.mod_start) begin
                red_busy_reg <= 1'b1;
            end else if (red_busy_reg && red_k_reg == 3'd0) begin
                red_busy_reg <= 1'b0;
                red_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mod_start) begin
            red_reg   <= angle_mag;
            red_k_reg <= 3'd6;
        end else if (red_busy_reg) begin
            if (red_reg >= red_sub) begin
                red_reg <= red_reg - red_sub;
            end
            red_k_reg <= red_k_reg - 3'd1;
        end
    end

    // angle reduction
    logic signed [26:0] a0, a1, a_fold;
    logic               flip_fold;

    always_comb begin
        if (angle_reg[31] && red_reg[24:0] != 25'd0) begin
            a0 = 27'(FULL_TURN_Q16) - 27'(red_reg[24:0]);
        end else begin
            a0 = 27'(red_reg[24:0]);
        end
        a1 = (a0 > $signed(27'(HALF_TURN_Q16))) ? a0 - 27'(FULL_TURN_Q16) : a0;
        flip_fold = 1'b0;
        a_fold    = a1;
        if (a1 > $signed(27'(QUARTER_TURN_Q16))) begin
            a_fold    = 27'(HALF_TURN_Q16) - a1;
            flip_fold = 1'b1;
        end else if (a1 < -$signed(27'(QUARTER_TURN_Q16))) begin
            a_fold    = -$signed(27'(HALF_TURN_Q16)) - a1;
            flip_fold = 1'b1;
        end
    end

    // cordic rotation
    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic signed [CW-1:0] dx, dy, at, xc, yc;
    logic [IW-1:0]        iter_reg;

    always_comb begin
        dx = y_reg >>> iter_reg;
        dy = x_reg >>> iter_reg;
        at = $signed({2'b00, ATAN_Q30[5'(iter_reg)]});
        if (x_reg > $signed(CW'(ONE_Q30))) begin
            xc = CW'(ONE_Q30);
        end else if (x_reg < -$signed(CW'(ONE_Q30))) begin
            xc = -$signed(CW'(ONE_Q30));
        end else begin
            xc = x_reg;
        end
        if (y_reg > $signed(CW'(ONE_Q30))) begin
            yc = CW'(ONE_Q30);
        end else if (y_reg < -$signed(CW'(ONE_Q30))) begin
            yc = -$signed(CW'(ONE_Q30));
        end else begin
            yc = y_reg;
        end
    end

    logic [9:0]         idx_reg;
    logic signed [31:0] step_reg;
    logic signed [42:0] prod_reg;
    logic signed [43:0] sum;
    logic signed [26:0] a_reg;
    logic               flip_reg;
    logic signed [54:0] rad_reg, rad_rnd;
    logic signed [31:0] tan_reg, cot_reg;

    assign sum     = {{12{start_reg[31]}}, start_reg} + {prod_reg[42], prod_reg};
    assign rad_rnd = rad_reg + 55'sd131072;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            idx_reg <= s_point_index;
        end
        if (cmd.div_start) begin
            neg_reg <= div_neg;
        end
        if (cmd.step_save) begin
            step_reg <= sat_quo(div_quo, neg_reg);
        end
        if (cmd.mul) begin
            prod_reg <= step_reg * $signed({1'b0, idx_reg});
        end
        if (cmd.add) begin
            if (sum > 44'sh0_7FFF_FFFF) begin
                angle_reg <= 32'sh7FFF_FFFF;
            end else if (sum < -44'sh0_8000_0000) begin
                angle_reg <= 32'sh8000_0000;
            end else begin
                angle_reg <= sum[31:0];
            end
        end
        if (cmd.fold) begin
            a_reg    <= a_fold;
            flip_reg <= flip_fold;
        end
        if (cmd.rad) begin
            rad_reg <= a_reg * $signed({1'b0, DEG_TO_RAD_Q32});
        end
        if (cmd.cordic_init) begin
            x_reg    <= CW'(CORDIC_GAIN_Q30);
            y_reg    <= '0;
            z_reg    <= CW'(rad_rnd >>> 18);
            iter_reg <= '0;
        end else if (cmd.cordic_step) begin
            if (!z_reg[CW-1]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
            iter_reg <= iter_reg + IW'(1);
        end
        if (cmd.clamp) begin
            s_reg   <= 32'(yc);
            c_reg   <= flip_reg ? 32'(-xc) : 32'(xc);
            tan_reg <= '0;
            cot_reg <= '0;
        end
        if (cmd.tan_save) begin
            tan_reg <= sat_quo(div_quo, neg_reg);
        end
        if (cmd.cot_save) begin
            cot_reg <= sat_quo(div_quo, neg_reg);
        end
    end

    // running extrema and result word
    logic signed [31:0] col_val, base_max, base_min, new_max, new_min;
    logic signed [31:0] max_reg, min_reg;
    logic               upd, tdef, cdef;
    logic               m_valid_reg;

    assign tdef = (c_reg != 32'sd0);
    assign cdef = (s_reg != 32'sd0);

    always_comb begin
        upd     = 1'b1;
        col_val = angle_reg;
        case (col_reg)
            COL_ANGLE: col_val = angle_reg;
            COL_SIN:   col_val = s_reg >>> 14;
            COL_COS:   col_val = c_reg >>> 14;
            COL_TAN: begin
                col_val = tan_reg;
                upd     = tdef;
            end
            COL_COT: begin
                col_val = cot_reg;
                upd     = cdef;
            end
            default:   upd = 1'b0;
        endcase
        base_max = (idx_reg == 10'd0) ? -$signed(EXTREME_START) : max_reg;
        base_min = (idx_reg == 10'd0) ? $signed(EXTREME_START) : min_reg;
        new_max  = (upd && col_val > base_max) ? col_val : base_max;
        new_min  = (upd && col_val < base_min) ? col_val : base_min;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            max_reg     <= -$signed(EXTREME_START);
            min_reg     <= $signed(EXTREME_START);
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
            max_reg     <= new_max;
            min_reg     <= new_min;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_angle_deg         <= angle_reg;
            m_sine              <= s_reg;
            m_cosine            <= c_reg;
            m_tangent           <= tan_reg;
            m_cotangent         <= cot_reg;
            m_tangent_defined   <= tdef;
            m_cotangent_defined <= cdef;
            m_column_max        <= new_max;
            m_column_min        <= new_min;
        end
    end

    assign m_valid = m_valid_reg;

    assign status.step_stale  = stale_reg;
    assign status.div_done    = div_done;
    assign status.mod_done    = red_done_reg;
    assign status.cordic_last = (iter_reg == IW'(CORDIC_STEPS - 1));
    assign status.c_zero      = !tdef;
    assign status.s_zero      = !cdef;
    assign status.m_free      = !m_valid_reg || m_ready;

endmodule

// ===== rtl/core/trig_table_sweep.sv =====
// a word's processing time is set mostly by the
// two 48-bit serial divides (tangent, cotangent), the cordic loop and the serial angle modulo
// an undefined tangent or cotangent skips its divide
// the first word after reset or a configuration register write also runs the step divide
// one word at a time; a held result stalls the next one
// reset: synchronous active-low aresetn restores configuration defaults and the extrema
module trig_table_sweep #(
    parameter int POINTS_MAX   = 1024,
    parameter int CORDIC_STEPS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [9:0]         s_point_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_angle_deg,
    output logic signed [31:0] m_sine,
    output logic signed [31:0] m_cosine,
    output logic signed [31:0] m_tangent,
    output logic signed [31:0] m_cotangent,
    output logic               m_tangent_defined,
    output logic               m_cotangent_defined,
    output logic signed [31:0] m_column_max,
    output logic signed [31:0] m_column_min,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import tts_pkg::*;

    tts_cmd_t    cmd;
    tts_status_t status;

    assign cfg_ready = 1'b1;

    tts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tts_dp #(
        .POINTS_MAX   (POINTS_MAX),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .s_point_index       (s_point_index),
        .cfg_valid           (cfg_valid),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_angle_deg         (m_angle_deg),
        .m_sine              (m_sine),
        .m_cosine            (m_cosine),
        .m_tangent           (m_tangent),
        .m_cotangent         (m_cotangent),
        .m_tangent_defined   (m_tangent_defined),
        .m_cotangent_defined (m_cotangent_defined),
        .m_column_max        (m_column_max),
        .m_column_min        (m_column_min)
    );

endmodule
